@@ rtl/ihex_pkg.sv @@
// Shared types and constants for the hex record loader.
// Used by the front parser, the command queue, the back end and the top level.
// No dependencies.
package ihex_pkg;

  // Input item modes.
  typedef enum logic [1:0] {
    MODE_CHAR  = 2'd0,
    MODE_END   = 2'd1,
    MODE_BREAK = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  // Result kinds.
  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Record status codes.
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_RANGE   = 2'd2
  } status_t;

  // Record type codes.
  localparam logic [7:0] REC_DATA      = 8'h00;
  localparam logic [7:0] REC_EOF       = 8'h01;
  localparam logic [7:0] REC_SEG_BASE  = 8'h02;
  localparam logic [7:0] REC_SEG_START = 8'h03;
  localparam logic [7:0] REC_LIN_BASE  = 8'h04;
  localparam logic [7:0] REC_LIN_START = 8'h05;

  // Work the back end carries out for one record.
  typedef enum logic [1:0] {
    CMD_STATUS = 2'd0,
    CMD_DATA   = 2'd1,
    CMD_START  = 2'd2
  } cmd_op_t;

  // Fixed values of the record format.
  localparam int         DIGIT_MIN     = 10;
  localparam logic [16:0] START_LO_ADDR = 17'h0FFFC;
  localparam logic [16:0] START_HI_ADDR = 17'h0FFFD;
  localparam logic [7:0] BASE_REC_COUNT  = 8'd2;
  localparam logic [7:0] START_REC_COUNT = 8'd4;

  // One queued record command.
  typedef struct packed {
    cmd_op_t     op;
    logic        bank;
    logic [16:0] start;
    logic        ext;
    logic [7:0]  count;
    logic [7:0]  b2;
    logic [7:0]  b3;
    status_t     status;
  } cmd_t;

  // Buffer bank handed back once its data has been written out.
  typedef struct packed {
    logic en;
    logic bank;
  } rel_t;

endpackage

@@ rtl/intel_hex_record_loader_unit.sv @@
// Top level of the hex record loader: front parser, command queue, back end.
// Depends on ihex_pkg, ihex_front, ihex_cmd_fifo and ihex_back.
//
//   Channel  Direction  Handshake             Beat contents
//   in_      input      in_valid / in_stall   mode, character
//   out_     output     out_valid / out_stall kind, write_address, extended_region,
//                                             write_data, status, last
//
// A character beat is taken every cycle while a record is being collected.
// An end-of-record beat starts the record check, which waits while the queue is full.
// The back end sends one result per cycle unless out_stall holds it: each data byte
// from the buffer or both start bytes, then the status, and then goes back to idle.
// Characters stall while the buffer bank for the next record is still being flushed.
// Reset is synchronous, active low, and clears base address and record state.
module intel_hex_record_loader_unit #(
  parameter int MAX_DATA_BYTES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [7:0]  in_character,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic [16:0] out_write_address,
  output logic        out_extended_region,
  output logic [7:0]  out_write_data,
  output logic [1:0]  out_status,
  output logic        out_last
);
  import ihex_pkg::*;

  localparam int IDXW = $clog2(MAX_DATA_BYTES + 1);

  logic            mem_wr_en;
  logic            mem_wr_bank;
  logic [IDXW-1:0] mem_wr_idx;
  logic [7:0]      mem_wr_data;
  logic            push;
  cmd_t            push_cmd;
  logic            fifo_full;
  logic            fifo_empty;
  logic            pop;
  cmd_t            head;
  rel_t            bank_rel;

  ihex_front #(.MAX_DATA_BYTES(MAX_DATA_BYTES)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_mode      (in_mode),
    .in_character (in_character),
    .mem_wr_en    (mem_wr_en),
    .mem_wr_bank  (mem_wr_bank),
    .mem_wr_idx   (mem_wr_idx),
    .mem_wr_data  (mem_wr_data),
    .push         (push),
    .push_cmd     (push_cmd),
    .fifo_full    (fifo_full),
    .bank_rel     (bank_rel)
  );

  ihex_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (fifo_full),
    .pop      (pop),
    .head     (head),
    .empty    (fifo_empty)
  );

  ihex_back #(.MAX_DATA_BYTES(MAX_DATA_BYTES)) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .mem_wr_en           (mem_wr_en),
    .mem_wr_bank         (mem_wr_bank),
    .mem_wr_idx          (mem_wr_idx),
    .mem_wr_data         (mem_wr_data),
    .fifo_empty          (fifo_empty),
    .head                (head),
    .pop                 (pop),
    .bank_rel            (bank_rel),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_kind            (out_kind),
    .out_write_address   (out_write_address),
    .out_extended_region (out_extended_region),
    .out_write_data      (out_write_data),
    .out_status          (out_status),
    .out_last            (out_last)
  );

endmodule

@@ rtl/ihex_front.sv @@
// Front end: accepts record characters, builds the record and checks it at its end.
// Writes data bytes into the back end's buffer and pushes one command per record.
// Depends on ihex_pkg.
module ihex_front #(
  parameter int MAX_DATA_BYTES = 32,
  localparam int IDXW = $clog2(MAX_DATA_BYTES + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       in_mode,
  input  logic [7:0]       in_character,
  output logic             mem_wr_en,
  output logic             mem_wr_bank,
  output logic [IDXW-1:0]  mem_wr_idx,
  output logic [7:0]       mem_wr_data,
  output logic             push,
  output ihex_pkg::cmd_t   push_cmd,
  input  logic             fifo_full,
  input  ihex_pkg::rel_t   bank_rel
);
  import ihex_pkg::*;

  localparam int DEPTH = MAX_DATA_BYTES + 1;
  localparam int CNTW  = $clog2(DEPTH + 1);
  localparam int DLIM  = 2 * (MAX_DATA_BYTES + 5);
  localparam int DCW   = $clog2(DLIM + 1);

  typedef enum logic [1:0] {
    F_COLLECT = 2'b01,
    F_EVAL    = 2'b10
  } fstate_t;

  // Returns {valid, value} for one ASCII hex digit.
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= "0" && c <= "9") begin
      r = {1'b1, 4'(c - "0")};
    end else if (c >= "A" && c <= "F") begin
      r = {1'b1, 4'(c - "A" + 8'd10)};
    end else if (c >= "a" && c <= "f") begin
      r = {1'b1, 4'(c - "a" + 8'd10)};
    end
    return r;
  endfunction

  fstate_t         state_r, state_nxt;
  logic [DCW-1:0]  digit_r, digit_nxt;
  logic [3:0]      high_r, high_nxt;
  logic [7:0]      sum_r, sum_nxt;
  logic [7:0]      count_r, count_nxt;
  logic [15:0]     addr_r, addr_nxt;
  logic [7:0]      type_r, type_nxt;
  logic [CNTW-1:0] stored_r, stored_nxt;
  logic [31:0]     base_r, base_nxt;
  logic            bad_r, bad_nxt;
  logic            space_r, space_nxt;
  logic [7:0]      dbyte_r [4];
  logic [7:0]      dbyte_nxt [4];
  logic            bank_r, bank_nxt;
  logic [1:0]      busy_r, busy_nxt;
  logic [32:0]     start_r, start_nxt;
  logic            inval_r, inval_nxt;

  logic            accept;
  logic [4:0]      hexd;
  logic [7:0]      byte_val;
  logic [17:0]     end_addr;
  cmd_t            cmd;

  assign in_stall = (state_r != F_COLLECT) || busy_r[bank_r];
  assign accept   = in_valid && !in_stall;
  assign hexd     = hex_decode(in_character);
  assign byte_val = {high_r, hexd[3:0]};
  assign end_addr = {1'b0, start_r[16:0]} + 18'(count_r) - 18'd1;

  assign mem_wr_bank = bank_r;
  assign mem_wr_idx  = stored_r[IDXW-1:0];
  assign mem_wr_data = byte_val;
  assign push_cmd    = cmd;

  // Record collection, end-of-record checks and command issue.
  always_comb begin
    state_nxt  = state_r;
    digit_nxt  = digit_r;
    high_nxt   = high_r;
    sum_nxt    = sum_r;
    count_nxt  = count_r;
    addr_nxt   = addr_r;
    type_nxt   = type_r;
    stored_nxt = stored_r;
    base_nxt   = base_r;
    bad_nxt    = bad_r;
    space_nxt  = space_r;
    dbyte_nxt  = dbyte_r;
    bank_nxt   = bank_r;
    busy_nxt   = busy_r;
    start_nxt  = start_r;
    inval_nxt  = inval_r;
    mem_wr_en  = 1'b0;
    push       = 1'b0;

    cmd        = '0;
    cmd.op     = CMD_STATUS;
    cmd.bank   = bank_r;
    cmd.start  = start_r[16:0];
    cmd.ext    = start_r[16];
    cmd.count  = count_r;
    cmd.b2     = dbyte_r[2];
    cmd.b3     = dbyte_r[3];
    cmd.status = ST_OK;

    // A flushed bank becomes free for a later record.
    if (bank_rel.en) begin
      busy_nxt[bank_rel.bank] = 1'b0;
    end

    unique case (state_r)
      F_COLLECT: begin
        if (accept) begin
          case (mode_t'(in_mode))
            MODE_CHAR: begin
              // Trailing spaces end the record text; anything after them is bad.
              if (in_character == " ") begin
                space_nxt = 1'b1;
              end else if (space_r) begin
                bad_nxt = 1'b1;
              end else if (!hexd[4] || bad_r || digit_r >= DCW'(DLIM)) begin
                bad_nxt = 1'b1;
              end else if (!digit_r[0]) begin
                high_nxt  = hexd[3:0];
                digit_nxt = digit_r + DCW'(1);
              end else begin
                digit_nxt = digit_r + DCW'(1);
                sum_nxt   = sum_r + byte_val;
                if (digit_r < DCW'(8)) begin
                  // Header bytes: count, address high, address low, type.
                  case (digit_r[2:1])
                    2'd0:    count_nxt = byte_val;
                    2'd3:    type_nxt  = byte_val;
                    default: addr_nxt  = {addr_r[7:0], byte_val};
                  endcase
                end else if (stored_r < CNTW'(DEPTH)) begin
                  mem_wr_en  = 1'b1;
                  stored_nxt = stored_r + CNTW'(1);
                  if (stored_r < CNTW'(4)) begin
                    dbyte_nxt[stored_r[1:0]] = byte_val;
                  end
                end else begin
                  bad_nxt = 1'b1;
                end
              end
            end
            MODE_END: begin
              inval_nxt = bad_r || (digit_r < DCW'(DIGIT_MIN)) || digit_r[0] ||
                          (stored_r == '0) || (count_r != 8'(stored_r) - 8'd1) ||
                          (sum_r != 8'd0);
              start_nxt = 33'(base_r) + 33'(addr_r);
              state_nxt = F_EVAL;
            end
            MODE_BREAK: begin
              base_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end

      F_EVAL: begin
        // Classify the record, pick its base update, push its command when not full.
        if (inval_r) begin
          cmd.status = ST_INVALID;
        end else begin
          case (type_r)
            REC_DATA: begin
              if (start_r[32:17] != '0 || (count_r != 8'd0 && end_addr[17])) begin
                cmd.status = ST_RANGE;
              end else if (count_r != 8'd0) begin
                cmd.op = CMD_DATA;
              end
            end
            REC_EOF: begin
              base_nxt = '0;
            end
            REC_SEG_BASE: begin
              if (count_r == BASE_REC_COUNT) begin
                base_nxt = (32'(dbyte_r[0]) << 12) + (32'(dbyte_r[1]) << 4);
              end
            end
            REC_LIN_BASE: begin
              if (count_r == BASE_REC_COUNT) begin
                base_nxt = {dbyte_r[0], dbyte_r[1], 16'h0000};
              end
            end
            REC_SEG_START, REC_LIN_START: begin
              if (count_r == START_REC_COUNT) begin
                cmd.op = CMD_START;
              end
            end
            default: begin
              cmd.status = ST_INVALID;
            end
          endcase
        end

        if (!fifo_full) begin
          push = 1'b1;
          if (cmd.op == CMD_DATA) begin
            busy_nxt[bank_r] = 1'b1;
            bank_nxt         = !bank_r;
          end
          digit_nxt  = '0;
          high_nxt   = '0;
          sum_nxt    = '0;
          count_nxt  = '0;
          addr_nxt   = '0;
          type_nxt   = '0;
          stored_nxt = '0;
          bad_nxt    = 1'b0;
          space_nxt  = 1'b0;
          state_nxt  = F_COLLECT;
        end else begin
          base_nxt = base_r;
        end
      end

      default: begin
        state_nxt = F_COLLECT;
      end
    endcase
  end

  // Control and record state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= F_COLLECT;
      digit_r  <= '0;
      high_r   <= '0;
      sum_r    <= '0;
      count_r  <= '0;
      addr_r   <= '0;
      type_r   <= '0;
      stored_r <= '0;
      base_r   <= '0;
      bad_r    <= 1'b0;
      space_r  <= 1'b0;
      bank_r   <= 1'b0;
      busy_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      digit_r  <= digit_nxt;
      high_r   <= high_nxt;
      sum_r    <= sum_nxt;
      count_r  <= count_nxt;
      addr_r   <= addr_nxt;
      type_r   <= type_nxt;
      stored_r <= stored_nxt;
      base_r   <= base_nxt;
      bad_r    <= bad_nxt;
      space_r  <= space_nxt;
      bank_r   <= bank_nxt;
      busy_r   <= busy_nxt;
    end
  end

  // Captured header bytes and end-of-record results.
  always_ff @(posedge clk) begin
    dbyte_r <= dbyte_nxt;
    start_r <= start_nxt;
    inval_r <= inval_nxt;
  end

  // A bank still being flushed is never overwritten.
  a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    mem_wr_en |-> !busy_r[bank_r])
    else $error("data byte written into a bank that is still being flushed");

  // Only a bank that was handed out comes back.
  a_release_taken: assert property (@(posedge clk) disable iff (!rst_n)
    bank_rel.en |-> busy_r[bank_rel.bank])
    else $error("release of a bank that was not in use");

  // A data command moves collection to the other bank.
  a_bank_swap: assert property (@(posedge clk) disable iff (!rst_n)
    (push && push_cmd.op == CMD_DATA) |=> (bank_r != $past(bank_r)))
    else $error("bank not swapped after a data command");

endmodule

@@ rtl/ihex_cmd_fifo.sv @@
// Two-entry queue of record commands between the front and back ends.
// Depends on ihex_pkg.
module ihex_cmd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  ihex_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output ihex_pkg::cmd_t head,
  output logic           empty
);
  import ihex_pkg::*;

  cmd_t       q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign head  = q_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = !wr_ptr_r;
    end
    if (pop) begin
      rd_ptr_nxt = !rd_ptr_r;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_cmd;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("command pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty))
    else $error("command popped from an empty queue");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("queue fill count out of range");

endmodule

@@ rtl/ihex_back.sv @@
// Back end: holds the two-bank data buffer and turns record commands into results.
// Emits byte writes, then the record status, through a registered output stage.
// Depends on ihex_pkg.
module ihex_back #(
  parameter int MAX_DATA_BYTES = 32,
  localparam int IDXW = $clog2(MAX_DATA_BYTES + 1)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            mem_wr_en,
  input  logic            mem_wr_bank,
  input  logic [IDXW-1:0] mem_wr_idx,
  input  logic [7:0]      mem_wr_data,
  input  logic            fifo_empty,
  input  ihex_pkg::cmd_t  head,
  output logic            pop,
  output ihex_pkg::rel_t  bank_rel,
  output logic            out_valid,
  input  logic            out_stall,
  output logic            out_kind,
  output logic [16:0]     out_write_address,
  output logic            out_extended_region,
  output logic [7:0]      out_write_data,
  output logic [1:0]      out_status,
  output logic            out_last
);
  import ihex_pkg::*;

  localparam int DEPTH = MAX_DATA_BYTES + 1;
  localparam int CNTW  = $clog2(DEPTH + 1);

  typedef enum logic [4:0] {
    B_IDLE   = 5'b00001,
    B_EMIT   = 5'b00010,
    B_LO     = 5'b00100,
    B_HI     = 5'b01000,
    B_STATUS = 5'b10000
  } bstate_t;

  logic [7:0]      mem [2][DEPTH];
  logic [7:0]      rdata_r;

  bstate_t         state_r, state_nxt;
  cmd_t            cmd_r, cmd_nxt;
  logic [CNTW-1:0] i_r, i_nxt;
  logic [16:0]     wa_r, wa_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_kind_r, out_kind_nxt;
  logic [16:0]     out_addr_r, out_addr_nxt;
  logic            out_ext_r, out_ext_nxt;
  logic [7:0]      out_data_r, out_data_nxt;
  status_t         out_status_r, out_status_nxt;
  logic            out_last_r, out_last_nxt;

  logic            can_load;
  logic            load;
  logic            rd_en;
  logic            rd_bank;
  logic [CNTW-1:0] next_i;
  logic [IDXW-1:0] rd_idx;

  assign can_load = !out_valid_r || !out_stall;
  assign next_i   = i_r + CNTW'(1);

  assign out_valid           = out_valid_r;
  assign out_kind            = out_kind_r;
  assign out_write_address   = out_addr_r;
  assign out_extended_region = out_ext_r;
  assign out_write_data      = out_data_r;
  assign out_status          = out_status_r;
  assign out_last            = out_last_r;

  // Command sequencer and output stage loading.
  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    i_nxt          = i_r;
    wa_nxt         = wa_r;
    pop            = 1'b0;
    rd_en          = 1'b0;
    rd_bank        = cmd_r.bank;
    rd_idx         = next_i[IDXW-1:0];
    load           = 1'b0;
    bank_rel       = '0;
    out_kind_nxt   = out_kind_r;
    out_addr_nxt   = out_addr_r;
    out_ext_nxt    = out_ext_r;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;

    unique case (state_r)
      B_IDLE: begin
        if (!fifo_empty) begin
          pop     = 1'b1;
          cmd_nxt = head;
          case (head.op)
            CMD_DATA: begin
              // Prefetch the first data byte.
              rd_en     = 1'b1;
              rd_bank   = head.bank;
              rd_idx    = '0;
              i_nxt     = '0;
              wa_nxt    = head.start;
              state_nxt = B_EMIT;
            end
            CMD_START: state_nxt = B_LO;
            default:   state_nxt = B_STATUS;
          endcase
        end
      end

      B_EMIT: begin
        if (can_load) begin
          load           = 1'b1;
          out_kind_nxt   = KIND_WRITE;
          out_addr_nxt   = wa_r;
          out_ext_nxt    = cmd_r.ext;
          out_data_nxt   = rdata_r;
          out_status_nxt = ST_OK;
          out_last_nxt   = 1'b0;
          wa_nxt         = wa_r + 17'd1;
          i_nxt          = next_i;
          if (8'(next_i) < cmd_r.count) begin
            rd_en = 1'b1;
          end else begin
            state_nxt = B_STATUS;
          end
        end
      end

      B_LO: begin
        if (can_load) begin
          load           = 1'b1;
          out_kind_nxt   = KIND_WRITE;
          out_addr_nxt   = START_LO_ADDR;
          out_ext_nxt    = 1'b0;
          out_data_nxt   = cmd_r.b2;
          out_status_nxt = ST_OK;
          out_last_nxt   = 1'b0;
          state_nxt      = B_HI;
        end
      end

      B_HI: begin
        if (can_load) begin
          load           = 1'b1;
          out_kind_nxt   = KIND_WRITE;
          out_addr_nxt   = START_HI_ADDR;
          out_ext_nxt    = 1'b0;
          out_data_nxt   = cmd_r.b3;
          out_status_nxt = ST_OK;
          out_last_nxt   = 1'b0;
          state_nxt      = B_STATUS;
        end
      end

      B_STATUS: begin
        if (can_load) begin
          load           = 1'b1;
          out_kind_nxt   = KIND_STATUS;
          out_addr_nxt   = '0;
          out_ext_nxt    = 1'b0;
          out_data_nxt   = '0;
          out_status_nxt = cmd_r.status;
          out_last_nxt   = 1'b1;
          bank_rel.en    = (cmd_r.op == CMD_DATA);
          bank_rel.bank  = cmd_r.bank;
          state_nxt      = B_IDLE;
        end
      end

      default: begin
        state_nxt = B_IDLE;
      end
    endcase

    out_valid_nxt = load ? 1'b1 : (out_stall ? out_valid_r : 1'b0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Command and output payload registers.
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    i_r          <= i_nxt;
    wa_r         <= wa_nxt;
    out_kind_r   <= out_kind_nxt;
    out_addr_r   <= out_addr_nxt;
    out_ext_r    <= out_ext_nxt;
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  // Data buffer: one write port from the front, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_wr_en) begin
      mem[mem_wr_bank][mem_wr_idx] <= mem_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= mem[rd_bank][rd_idx];
    end
  end

  // The status result, and only it, closes an item's results.
  a_last_is_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_last_r == (out_kind_r == KIND_STATUS)))
    else $error("last flag does not match result kind");

  a_write_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == KIND_WRITE) |-> (out_status_r == ST_OK))
    else $error("byte write carries a nonzero status");

  a_emit_data_only: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_EMIT) |-> (cmd_r.op == CMD_DATA && 8'(i_r) < cmd_r.count))
    else $error("buffer flush outside a data command");

endmodule

@@ tb/intel_hex_record_loader_unit_test.sv @@
// Self-checking bench for the hex record loader: streams records, checks every result beat.
// Uses ihex_pkg for modes, status codes and record types; needs only the RTL.
// A scoreboard class predicts the result beats; tasks drive input, a process stalls output.
module intel_hex_record_loader_unit_test;
  import ihex_pkg::*;

  localparam int MAX_DATA     = 32;
  localparam int RANDOM_BEATS = 150;
  localparam int LONG_HOLD    = 300;
  localparam int SETTLE       = 40;
  localparam int CYCLE_LIMIT  = 400000;
  localparam logic [7:0] SPACE_CHAR = 8'h20;

  // One result beat, field by field.
  typedef struct packed {
    logic        kind;
    logic [16:0] address;
    logic        ext;
    logic [7:0]  data;
    status_t     status;
    logic        last;
  } load_result_t;

  // One input beat.
  typedef struct packed {
    mode_t      mode;
    logic [7:0] ch;
  } beat_t;

  typedef logic [7:0] byte_q_t[$];

  // Ways a record can be damaged on its way in.
  typedef enum int {
    FLAW_NONE,
    FLAW_SUM,
    FLAW_COUNT,
    FLAW_BADCHAR,
    FLAW_ODD,
    FLAW_SPACES,
    FLAW_SPACE_MID,
    FLAW_BREAK,
    FLAW_IGNORED,
    FLAW_TRUNC
  } flaw_t;

  // Predicts the result beats of the loader and checks the ones that come out.
  class load_scoreboard;
    localparam int DIGIT_LIMIT = 2 * (MAX_DATA + 5);

    int          digits;
    logic [3:0]  hi_nib;
    logic [7:0]  sum;
    logic [7:0]  count_byte;
    logic [15:0] offset;
    logic [7:0]  type_byte;
    logic [7:0]  payload[0:MAX_DATA];
    int          stored;
    logic [31:0] base;
    bit          bad;
    bit          spaced;

    load_result_t pending_results[$];
    int errors;
    int writes_seen;
    int status_tally[3];

    function new();
      clear_record();
      base = '0;
    endfunction

    static function int nibble_of(logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c - "0");
      if (c >= "A" && c <= "F") return int'(c - "A") + 10;
      if (c >= "a" && c <= "f") return int'(c - "a") + 10;
      return -1;
    endfunction

    function void clear_record();
      digits     = 0;
      hi_nib     = '0;
      sum        = '0;
      count_byte = '0;
      offset     = '0;
      type_byte  = '0;
      stored     = 0;
      bad        = 1'b0;
      spaced     = 1'b0;
    endfunction

    function void forecast_write(logic [16:0] addr, logic ext, logic [7:0] data);
      load_result_t r;
      r.kind    = KIND_WRITE;
      r.address = addr;
      r.ext     = ext;
      r.data    = data;
      r.status  = ST_OK;
      r.last    = 1'b0;
      pending_results.push_back(r);
    endfunction

    // Pairs hex digits into bytes and files them into the record fields.
    function void take_char(logic [7:0] c);
      int v;
      int idx;
      logic [7:0] val;
      if (c == SPACE_CHAR) begin
        spaced = 1'b1;
        return;
      end
      if (spaced) begin
        bad = 1'b1;
        return;
      end
      v = nibble_of(c);
      if (v < 0 || bad || digits >= DIGIT_LIMIT) begin
        bad = 1'b1;
        return;
      end
      if (digits % 2 == 0) begin
        hi_nib = v[3:0];
        digits++;
        return;
      end
      val = {hi_nib, v[3:0]};
      idx = digits / 2;
      digits++;
      sum += val;
      if (idx == 0) count_byte = val;
      else if (idx == 1 || idx == 2) offset = {offset[7:0], val};
      else if (idx == 3) type_byte = val;
      else if (stored < MAX_DATA + 1) begin
        payload[stored] = val;
        stored++;
      end else bad = 1'b1;
    endfunction

    // Applies a finished record and forecasts its writes and the status beat.
    function void finish_record();
      status_t st;
      longint unsigned start;
      logic ext;
      load_result_t r;
      st = ST_OK;
      if (bad || digits < DIGIT_MIN || digits % 2 != 0 || stored == 0 ||
          int'(count_byte) != stored - 1 || sum != 8'd0) begin
        st = ST_INVALID;
      end else begin
        case (type_byte)
          REC_DATA: begin
            start = longint'(base) + offset;
            if (start > 64'h1FFFF ||
                (count_byte != 8'd0 && start + count_byte - 1 > 64'h1FFFF)) begin
              st = ST_RANGE;
            end else begin
              ext = (start >= 64'h10000);
              for (int i = 0; i < count_byte && i < MAX_DATA; i++)
                forecast_write(17'(start + i), ext, payload[i]);
            end
          end
          REC_EOF: base = '0;
          REC_SEG_BASE: begin
            if (count_byte == BASE_REC_COUNT)
              base = payload[0] * 32'h1000 + payload[1] * 32'h10;
          end
          REC_LIN_BASE: begin
            if (count_byte == BASE_REC_COUNT)
              base = payload[0] * 32'h1000000 + payload[1] * 32'h10000;
          end
          REC_SEG_START, REC_LIN_START: begin
            if (count_byte == START_REC_COUNT) begin
              forecast_write(START_LO_ADDR, 1'b0, payload[2]);
              forecast_write(START_HI_ADDR, 1'b0, payload[3]);
            end
          end
          default: st = ST_INVALID;
        endcase
      end
      r.kind    = KIND_STATUS;
      r.address = '0;
      r.ext     = 1'b0;
      r.data    = '0;
      r.status  = st;
      r.last    = 1'b1;
      pending_results.push_back(r);
      clear_record();
    endfunction

    // Notes one accepted input beat.
    function void note_beat(mode_t mode, logic [7:0] ch);
      case (mode)
        MODE_CHAR:  take_char(ch);
        MODE_END:   finish_record();
        MODE_BREAK: base = '0;
        default: ;
      endcase
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
        errors++;
      end
    endfunction

    // Checks one accepted result beat against the oldest forecast.
    function void check_beat(load_result_t got);
      load_result_t want;
      if (pending_results.size() == 0) begin
        $error("result beat with nothing forecast: kind %0d address 'h%0h data 'h%0h",
               got.kind, got.address, got.data);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("kind", want.kind, got.kind);
      compare_field("write_address", want.address, got.address);
      compare_field("extended_region", want.ext, got.ext);
      compare_field("write_data", want.data, got.data);
      compare_field("status", want.status, got.status);
      compare_field("last", want.last, got.last);
      if (want.kind == KIND_STATUS) status_tally[want.status]++;
      else writes_seen++;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_mode;
  logic [7:0]  in_character;
  logic        out_valid;
  logic        out_stall;
  logic        out_kind;
  logic [16:0] out_write_address;
  logic        out_extended_region;
  logic [7:0]  out_write_data;
  logic [1:0]  out_status;
  logic        out_last;

  load_scoreboard board;
  int idle_odds;
  bit hold_request;
  int beats_sent;
  int cycle_count;

  intel_hex_record_loader_unit #(
    .MAX_DATA_BYTES(MAX_DATA)
  ) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_mode             (in_mode),
    .in_character        (in_character),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_kind            (out_kind),
    .out_write_address   (out_write_address),
    .out_extended_region (out_extended_region),
    .out_write_data      (out_write_data),
    .out_status          (out_status),
    .out_last            (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Overall time limit.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("intel_hex_record_loader_unit: mismatch");
    $finish;
  end

  // Result side: check each accepted beat.
  always @(posedge clk) begin
    load_result_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.kind    = out_kind;
      got.address = out_write_address;
      got.ext     = out_extended_region;
      got.data    = out_write_data;
      got.status  = status_t'(out_status);
      got.last    = out_last;
      board.check_beat(got);
    end
  end

  // Result side: random stall bursts, plus one long hold on request.
  initial begin
    int held;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        for (held = 0; held < LONG_HOLD; held++) @(negedge clk);
        out_stall <= 1'b0;
      end else if (idle_odds != 0 && $urandom_range(1, 2 * idle_odds) == 1) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic beat_t make_beat(mode_t m, logic [7:0] c);
    beat_t b;
    b.mode = m;
    b.ch   = c;
    return b;
  endfunction

  // Hex digit in either letter case.
  function automatic logic [7:0] hex_digit(logic [3:0] n);
    if (n < 4'd10) return "0" + n;
    return ($urandom_range(0, 1) ? "a" : "A") + (n - 4'd10);
  endfunction

  function automatic logic [7:0] junk_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (load_scoreboard::nibble_of(c) >= 0 || c == SPACE_CHAR);
    return c;
  endfunction

  function automatic byte_q_t random_bytes(int n);
    byte_q_t q;
    for (int i = 0; i < n; i++) q.push_back(8'($urandom_range(0, 255)));
    return q;
  endfunction

  function automatic byte_q_t two_bytes(logic [7:0] a, logic [7:0] b);
    byte_q_t q;
    q = {a, b};
    return q;
  endfunction

  // Sends one beat, with an optional idle burst in front, and waits for acceptance.
  task automatic send_beat(input beat_t b);
    if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_mode      <= b.mode;
    in_character <= b.ch;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_beat(b.mode, b.ch);
    beats_sent++;
    @(negedge clk);
  endtask

  // Builds a record as hex text, applies a flaw, and sends it with its end beat.
  task automatic send_record(input logic [7:0] rtype, input logic [15:0] offset,
                             input byte_q_t data, input flaw_t flaw,
                             input logic [7:0] junk);
    logic [7:0] raw[$];
    logic [7:0] sum;
    beat_t beats[$];
    int pos;
    int keep;
    raw.push_back(8'(data.size()) + (flaw == FLAW_COUNT ? 8'd1 : 8'd0));
    raw.push_back(offset[15:8]);
    raw.push_back(offset[7:0]);
    raw.push_back(rtype);
    foreach (data[i]) raw.push_back(data[i]);
    sum = 8'd0;
    foreach (raw[i]) sum += raw[i];
    raw.push_back(8'd0 - sum + (flaw == FLAW_SUM ? 8'd1 : 8'd0));
    foreach (raw[i]) begin
      beats.push_back(make_beat(MODE_CHAR, hex_digit(raw[i][7:4])));
      beats.push_back(make_beat(MODE_CHAR, hex_digit(raw[i][3:0])));
    end
    pos = $urandom_range(0, beats.size() - 2);
    case (flaw)
      FLAW_BADCHAR:   beats[pos].ch = junk;
      FLAW_ODD:       beats.delete(beats.size() - 1);
      FLAW_SPACES: begin
        repeat ($urandom_range(1, 3)) beats.push_back(make_beat(MODE_CHAR, SPACE_CHAR));
      end
      FLAW_SPACE_MID: beats.insert(pos, make_beat(MODE_CHAR, SPACE_CHAR));
      FLAW_BREAK:     beats.insert(pos, make_beat(MODE_BREAK, 8'($urandom_range(0, 255))));
      FLAW_IGNORED:   beats.insert(pos, make_beat(MODE_NONE, 8'($urandom_range(0, 255))));
      FLAW_TRUNC: begin
        keep = $urandom_range(0, 9);
        while (beats.size() > keep) beats.delete(beats.size() - 1);
      end
      default: ;
    endcase
    beats.push_back(make_beat(MODE_END, 8'($urandom_range(0, 255))));
    foreach (beats[i]) send_beat(beats[i]);
  endtask

  // Random record, mostly well formed.
  task automatic send_random_record();
    int pick;
    int n;
    logic [7:0] rtype;
    logic [15:0] offset;
    byte_q_t data;
    flaw_t flaw;
    pick = $urandom_range(0, 99);
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 32) : $urandom_range(0, 8);
    offset = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(16'hFFC0, 16'hFFFF))
                                         : 16'($urandom_range(0, 16'hFFFF));
    if (pick < 60) begin
      rtype = REC_DATA;
      data = ($urandom_range(0, 49) == 0) ? random_bytes($urandom_range(33, 36))
                                          : random_bytes(n);
    end else if (pick < 70) begin
      rtype = REC_SEG_BASE;
      data = two_bytes(8'($urandom_range(0, 8'h1F)), 8'($urandom_range(0, 255)));
    end else if (pick < 80) begin
      rtype = REC_LIN_BASE;
      data = two_bytes(($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : 8'd0,
                       8'($urandom_range(0, 1)));
    end else if (pick < 86) begin
      rtype = $urandom_range(0, 1) ? REC_SEG_START : REC_LIN_START;
      data = random_bytes(4);
    end else if (pick < 91) begin
      rtype = REC_EOF;
      data = random_bytes(0);
    end else begin
      rtype = 8'($urandom_range(6, 255));
      data = random_bytes($urandom_range(0, 4));
    end
    // Base and start records with the wrong byte count now and then.
    if (pick >= 60 && pick < 86 && $urandom_range(0, 7) == 0)
      data = random_bytes($urandom_range(0, 6));
    flaw = FLAW_NONE;
    if ($urandom_range(0, 99) < 25) flaw = flaw_t'($urandom_range(FLAW_SUM, FLAW_TRUNC));
    send_record(rtype, offset, data, flaw, junk_char());
  endtask

  // Drops valid and waits until every forecast result has been checked.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (board.pending() != 0) @(negedge clk);
  endtask

  // Stimulus: reset, directed records, a long receiver hold, then random records.
  initial begin
    byte_q_t edge_data;
    int random_start;
    int records;
    board        = new();
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_mode      = MODE_CHAR;
    in_character = 8'd0;
    idle_odds    = 6;
    hold_request = 1'b0;
    beats_sent   = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Data records at the edges of size and address.
    edge_data = random_bytes(MAX_DATA);
    edge_data[0] = 8'h00;
    edge_data[1] = 8'hFF;
    send_record(REC_DATA, 16'h0000, random_bytes(0), FLAW_NONE, 8'h00);
    send_record(REC_DATA, 16'h0000, edge_data, FLAW_NONE, 8'h00);
    send_record(REC_DATA, 16'hFFFE, random_bytes(4), FLAW_NONE, 8'h00);
    // Linear base 0x10000: a record ending on the top byte, then one past it.
    send_record(REC_LIN_BASE, 16'h0000, two_bytes(8'h00, 8'h01), FLAW_NONE, 8'h00);
    send_record(REC_DATA, 16'hFFFE, random_bytes(2), FLAW_NONE, 8'h00);
    send_record(REC_DATA, 16'hFFFF, random_bytes(2), FLAW_NONE, 8'h00);
    // Segment base far out of range, then a break clears it.
    send_record(REC_SEG_BASE, 16'h0000, two_bytes(8'hFF, 8'hFF), FLAW_NONE, 8'h00);
    send_record(REC_DATA, 16'h0000, random_bytes(1), FLAW_NONE, 8'h00);
    send_beat(make_beat(MODE_BREAK, 8'hFF));
    send_beat(make_beat(MODE_NONE, 8'h00));
    send_record(REC_DATA, 16'h1234, random_bytes(3), FLAW_NONE, 8'h00);
    // End-of-file record clears a segment base.
    send_record(REC_SEG_BASE, 16'h0000, two_bytes(8'h10, 8'h00), FLAW_NONE, 8'h00);
    send_record(REC_EOF, 16'h0000, random_bytes(0), FLAW_NONE, 8'h00);
    send_record(REC_DATA, 16'h8000, random_bytes(2), FLAW_NONE, 8'h00);
    // Start records, and base or start records with the wrong count.
    send_record(REC_SEG_START, 16'h0000, random_bytes(4), FLAW_NONE, 8'h00);
    send_record(REC_LIN_START, 16'h0000, random_bytes(4), FLAW_NONE, 8'h00);
    send_record(REC_SEG_BASE, 16'h0000, random_bytes(3), FLAW_NONE, 8'h00);
    send_record(REC_LIN_START, 16'h0000, random_bytes(2), FLAW_NONE, 8'h00);
    send_record(8'h06, 16'h0000, random_bytes(2), FLAW_NONE, 8'h00);
    send_record(8'hFF, 16'hFFFF, random_bytes(1), FLAW_NONE, 8'h00);
    // Damaged records.
    send_record(REC_DATA, 16'h0100, random_bytes(1), FLAW_SUM, 8'h00);
    send_record(REC_DATA, 16'h0100, random_bytes(1), FLAW_COUNT, 8'h00);
    send_record(REC_DATA, 16'h0100, random_bytes(1), FLAW_BADCHAR, 8'h00);
    send_record(REC_DATA, 16'h0100, random_bytes(1), FLAW_BADCHAR, 8'hFF);
    send_record(REC_DATA, 16'h0100, random_bytes(1), FLAW_BADCHAR, "G");
    send_record(REC_DATA, 16'h0100, random_bytes(1), FLAW_ODD, 8'h00);
    send_record(REC_DATA, 16'h0100, random_bytes(4), FLAW_TRUNC, 8'h00);
    send_record(REC_DATA, 16'h0200, random_bytes(1), FLAW_SPACES, 8'h00);
    send_record(REC_DATA, 16'h0200, random_bytes(1), FLAW_SPACE_MID, 8'h00);
    send_record(REC_DATA, 16'h0300, random_bytes(1), FLAW_IGNORED, 8'h00);
    send_record(REC_LIN_BASE, 16'h0000, two_bytes(8'h00, 8'h01), FLAW_NONE, 8'h00);
    send_record(REC_DATA, 16'h0400, random_bytes(1), FLAW_BREAK, 8'h00);
    send_record(REC_DATA, 16'h0000, random_bytes(MAX_DATA + 1), FLAW_NONE, 8'h00);
    send_beat(make_beat(MODE_END, 8'h80));
    wait_drained();

    // Receiver holds off while records keep coming, so the block backs up.
    idle_odds = 0;
    hold_request = 1'b1;
    repeat (4) send_record(REC_DATA, 16'($urandom_range(0, 16'hFFF0)), random_bytes(2),
                           FLAW_NONE, 8'h00);
    wait_drained();

    // Random records, with idling varied by stretch and none near the end.
    random_start = beats_sent;
    records = 0;
    while (beats_sent - random_start < RANDOM_BEATS) begin
      if (records % 8 == 0) begin
        case ($urandom_range(0, 3))
          0: idle_odds = 0;
          1: idle_odds = 3;
          2: idle_odds = 6;
          default: idle_odds = 10;
        endcase
      end
      if (beats_sent - random_start > RANDOM_BEATS - 50) idle_odds = 0;
      if (records == 3) wait_drained();
      if ($urandom_range(0, 14) == 0)
        send_beat(make_beat($urandom_range(0, 1) ? MODE_BREAK : MODE_NONE,
                            8'($urandom_range(0, 255))));
      send_random_record();
      records++;
    end
    wait_drained();
    repeat (SETTLE) @(negedge clk);

    $display("Sent %0d input beats; checked %0d byte writes and %0d record status beats",
             beats_sent, board.writes_seen,
             board.status_tally[0] + board.status_tally[1] + board.status_tally[2]);
    $display("Record outcomes: %0d applied, %0d invalid, %0d out of range.",
             board.status_tally[ST_OK], board.status_tally[ST_INVALID],
             board.status_tally[ST_RANGE]);
    if (board.errors == 0) begin
      $display("intel_hex_record_loader_unit: match");
    end else begin
      $display("intel_hex_record_loader_unit: mismatch");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/ihex_pkg.sv
rtl/ihex_front.sv
rtl/ihex_cmd_fifo.sv
rtl/ihex_back.sv
rtl/intel_hex_record_loader_unit.sv
tb/intel_hex_record_loader_unit_test.sv
